@@ rtl/i2c_mbe_pkg.sv @@
// shared types and constants for the i2c master byte engine
// no dependencies; imported by i2c_mbe_core and i2c_master_byte_engine
`timescale 1ns / 1ps

package i2c_mbe_pkg;

    // field and state widths
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W = 4;
    localparam int PHASE_W   = 5;
    localparam int DELAY_W   = 11;   // 5 us * 255 ticks - 1 fits in 11 bits
    localparam int POLL_W    = 8;
    localparam int US_W      = 3;

    // command opcodes
    localparam logic [OP_W-1:0] OP_NOP      = 3'd0;
    localparam logic [OP_W-1:0] OP_START    = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE    = 3'd3;
    localparam logic [OP_W-1:0] OP_WAIT_ACK = 3'd4;
    localparam logic [OP_W-1:0] OP_READ     = 3'd5;

    // configuration register indexes
    localparam logic CFG_TICKS_PER_US = 1'b0;
    localparam logic CFG_ACK_TIMEOUT  = 1'b1;

    // bus sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_A    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_B    = 5'd2;
    localparam logic [PHASE_W-1:0] PH_SP_A    = 5'd3;
    localparam logic [PHASE_W-1:0] PH_SP_B    = 5'd4;
    localparam logic [PHASE_W-1:0] PH_WR_LO   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_WR_HI   = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WA_A    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WA_B    = 5'd8;
    localparam logic [PHASE_W-1:0] PH_WA_POLL = 5'd9;
    localparam logic [PHASE_W-1:0] PH_RD_LO   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_RD_HI   = 5'd11;
    localparam logic [PHASE_W-1:0] PH_AK_LO   = 5'd12;
    localparam logic [PHASE_W-1:0] PH_AK_HI   = 5'd13;

    // half-bit segment lengths in microseconds
    localparam logic [US_W-1:0] US_1 = 3'd1;
    localparam logic [US_W-1:0] US_2 = 3'd2;
    localparam logic [US_W-1:0] US_4 = 3'd4;
    localparam logic [US_W-1:0] US_5 = 3'd5;

    // one tick request
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [BYTE_W-1:0] data_byte;
        logic              send_ack;
        logic              sda_in;
    } cmd_t;

    // configuration registers
    typedef struct packed {
        logic [7:0] ticks_per_us;
        logic [7:0] ack_timeout_polls;
    } cfg_t;

    // one tick result
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] read_byte;
        logic              no_ack;
    } res_t;

    // segment length in ticks, minus one; rate of zero counts as one
    function automatic logic [DELAY_W-1:0] seg_ticks(input logic [US_W-1:0] us,
                                                      input logic [7:0] rate);
        logic [DELAY_W-1:0] r;
        logic [DELAY_W-1:0] prod;
        r    = (rate == 8'd0) ? DELAY_W'(1) : DELAY_W'(rate);
        prod = DELAY_W'(us) * r;
        return prod - DELAY_W'(1);
    endfunction

endpackage

@@ rtl/i2c_master_byte_engine.sv @@
// i2c master byte engine top level: request register, sequencer core, result register
// depends on i2c_mbe_pkg and i2c_mbe_core
`timescale 1ns / 1ps
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  s_opcode s_data_byte s_send_ack s_sda_in
//  m_        out        m_valid / m_ready  m_scl_out m_sda_out m_busy_res m_done_res
//                                          m_read_byte m_no_ack
//  cfg_      in         cfg_we             cfg_index cfg_data
//
//  one request per cycle sustained while m_ready is high; each request yields one result
//  through the request register, then the result register, the sequencer step sits between them.
//  aresetn is synchronous, active low; registers return to 1 tick/us, 250 polls,
//  bus released high and sequencer idle.
//  with m_ready low the result holds and one more request parks in the request register.

module i2c_master_byte_engine
    import i2c_mbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic              s_send_ack,
    input  logic              s_sda_in,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_scl_out,
    output logic              m_sda_out,
    output logic              m_busy_res,
    output logic              m_done_res,
    output logic [BYTE_W-1:0] m_read_byte,
    output logic              m_no_ack,

    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd_reg;
    logic in_valid_reg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic advance;

    // move the parked request into the result stage
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_us      <= 8'd1;
            cfg_reg.ack_timeout_polls <= 8'd250;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TICKS_PER_US: cfg_reg.ticks_per_us      <= cfg_data;
                CFG_ACK_TIMEOUT:  cfg_reg.ack_timeout_polls <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg.opcode    <= s_opcode;
            cmd_reg.data_byte <= s_data_byte;
            cmd_reg.send_ack  <= s_send_ack;
            cmd_reg.sda_in    <= s_sda_in;
        end
    end

    // sequencer step
    i2c_mbe_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cmd     (cmd_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl_out   = res_reg.scl_out;
    assign m_sda_out   = res_reg.sda_out;
    assign m_busy_res  = res_reg.busy;
    assign m_done_res  = res_reg.done;
    assign m_read_byte = res_reg.read_byte;
    assign m_no_ack    = res_reg.no_ack;

    // a completing command leaves the engine idle
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.done |-> !res_reg.busy)
        else $error("done reported while still busy");

    // an empty result stage never blocks requests
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("request stalled with empty result stage");

    // a request that advances always shows up as a result
    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced request lost");

    // a parked request with no result waiting advances at once
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |-> advance)
        else $error("request held with free result stage");

endmodule

@@ rtl/i2c_mbe_core.sv @@
// bus sequencer state and its one-tick next-state logic
// depends on i2c_mbe_pkg
`timescale 1ns / 1ps

module i2c_mbe_core
    import i2c_mbe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic step_en,
    input  cmd_t cmd,
    input  cfg_t cfg,
    output res_t res
);

    logic [PHASE_W-1:0]   phase_reg,     phase_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg,   bit_idx_next;
    logic [BYTE_W-1:0]    shift_reg,     shift_next;
    logic [DELAY_W-1:0]   delay_reg,     delay_next;
    logic [POLL_W-1:0]    poll_reg,      poll_next;
    logic                 scl_reg,       scl_next;
    logic                 sda_reg,       sda_next;
    logic                 ack_choice_reg, ack_choice_next;
    logic                 ack_miss_reg,  ack_miss_next;
    logic [BYTE_W-1:0]    last_read_reg, last_read_next;
    logic                 done;
    logic [BIT_IDX_W-1:0] bit_inc;
    logic [POLL_W:0]      poll_inc;

    assign bit_inc  = bit_idx_reg + BIT_IDX_W'(1);
    assign poll_inc = {1'b0, poll_reg} + (POLL_W+1)'(1);

    // one tick of the sequencer
    always_comb begin
        phase_next      = phase_reg;
        bit_idx_next    = bit_idx_reg;
        shift_next      = shift_reg;
        delay_next      = delay_reg;
        poll_next       = poll_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        ack_miss_next   = ack_miss_reg;
        last_read_next  = last_read_reg;
        done            = 1'b0;

        if (phase_reg != PH_IDLE && delay_reg != '0) begin
            delay_next = delay_reg - DELAY_W'(1);
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    case (cmd.opcode)
                        OP_START: begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            phase_next = PH_ST_A;
                            delay_next = seg_ticks(US_4, cfg.ticks_per_us);
                        end
                        OP_STOP: begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            phase_next = PH_SP_A;
                            delay_next = seg_ticks(US_4, cfg.ticks_per_us);
                        end
                        OP_WRITE: begin
                            bit_idx_next = '0;
                            scl_next     = 1'b0;
                            sda_next     = cmd.data_byte[BYTE_W-1];
                            shift_next   = {cmd.data_byte[BYTE_W-2:0], 1'b0};
                            phase_next   = PH_WR_LO;
                            delay_next   = seg_ticks(US_5, cfg.ticks_per_us);
                        end
                        OP_WAIT_ACK: begin
                            ack_miss_next = 1'b0;
                            poll_next     = '0;
                            sda_next      = 1'b1;
                            phase_next    = PH_WA_A;
                            delay_next    = seg_ticks(US_1, cfg.ticks_per_us);
                        end
                        OP_READ: begin
                            ack_choice_next = cmd.send_ack;
                            shift_next      = '0;
                            bit_idx_next    = '0;
                            sda_next        = 1'b1;
                            scl_next        = 1'b0;
                            phase_next      = PH_RD_LO;
                            delay_next      = seg_ticks(US_5, cfg.ticks_per_us);
                        end
                        default: begin
                            // tick only, or opcode with no meaning
                        end
                    endcase
                end
                PH_ST_A: begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST_B;
                    delay_next = seg_ticks(US_4, cfg.ticks_per_us);
                end
                PH_ST_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_SP_A: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_SP_B;
                    delay_next = seg_ticks(US_4, cfg.ticks_per_us);
                end
                PH_SP_B: begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_WR_LO: begin
                    scl_next   = 1'b1;
                    phase_next = PH_WR_HI;
                    delay_next = seg_ticks(US_5, cfg.ticks_per_us);
                end
                PH_WR_HI: begin
                    scl_next     = 1'b0;
                    bit_idx_next = bit_inc;
                    if (bit_inc >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else begin
                        sda_next   = shift_reg[BYTE_W-1];
                        shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        phase_next = PH_WR_LO;
                        delay_next = seg_ticks(US_5, cfg.ticks_per_us);
                    end
                end
                PH_WA_A: begin
                    scl_next   = 1'b1;
                    phase_next = PH_WA_B;
                    delay_next = seg_ticks(US_1, cfg.ticks_per_us);
                end
                PH_WA_B, PH_WA_POLL: begin
                    phase_next = PH_WA_POLL;
                    delay_next = '0;
                    if (!cmd.sda_in) begin
                        // slave pulled sda low: acknowledged
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else if (poll_inc > {1'b0, cfg.ack_timeout_polls}) begin
                        // timed out: flag it and run a stop sequence
                        ack_miss_next = 1'b1;
                        scl_next      = 1'b0;
                        sda_next      = 1'b0;
                        phase_next    = PH_SP_A;
                        delay_next    = seg_ticks(US_4, cfg.ticks_per_us);
                    end else begin
                        poll_next = poll_inc[POLL_W-1:0];
                    end
                end
                PH_RD_LO: begin
                    scl_next   = 1'b1;
                    shift_next = {shift_reg[BYTE_W-2:0], cmd.sda_in};
                    phase_next = PH_RD_HI;
                    delay_next = seg_ticks(US_5, cfg.ticks_per_us);
                end
                PH_RD_HI: begin
                    scl_next     = 1'b0;
                    bit_idx_next = bit_inc;
                    if (bit_inc >= BIT_IDX_W'(BITS_PER_BYTE)) begin
                        last_read_next = shift_reg;
                        sda_next       = ~ack_choice_reg;
                        phase_next     = PH_AK_LO;
                        delay_next     = seg_ticks(US_2, cfg.ticks_per_us);
                    end else begin
                        phase_next = PH_RD_LO;
                        delay_next = seg_ticks(US_5, cfg.ticks_per_us);
                    end
                end
                PH_AK_LO: begin
                    scl_next   = 1'b1;
                    phase_next = PH_AK_HI;
                    delay_next = seg_ticks(US_2, cfg.ticks_per_us);
                end
                PH_AK_HI: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                end
            endcase
        end
    end

    // result of this tick, taken from the updated state
    always_comb begin
        res.scl_out   = scl_next;
        res.sda_out   = sda_next;
        res.busy      = (phase_next != PH_IDLE);
        res.done      = done;
        res.read_byte = last_read_next;
        res.no_ack    = ack_miss_next;
    end

    // state registers advance once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_idx_reg    <= '0;
            shift_reg      <= '0;
            delay_reg      <= '0;
            poll_reg       <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            ack_miss_reg   <= 1'b0;
            last_read_reg  <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            bit_idx_reg    <= bit_idx_next;
            shift_reg      <= shift_next;
            delay_reg      <= delay_next;
            poll_reg       <= poll_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_choice_reg <= ack_choice_next;
            ack_miss_reg   <= ack_miss_next;
            last_read_reg  <= last_read_next;
        end
    end

endmodule
